### rtl/core/sdt_pkg.sv
// Shared types and constants for the source sequence duplicate table.
package sdt_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int FUNC_W      = 2;
    localparam int HOST_W      = 16;
    localparam int SEQ_W       = 8;
    localparam int STATUS_W    = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CHECK   = 2'd0,
        FUNC_REPLACE = 2'd1,
        FUNC_DELETE  = 2'd2,
        FUNC_CLEAR   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_DELETED   = 3'd4,
        ST_NOTFOUND  = 3'd5,
        ST_CLEARED   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RESOLVE,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic resolve;
        logic emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_is_clear;
        logic idx_last;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/core/source_sequence_duplicate_table.sv
// Duplicate-frame table of ENTRIES host/sequence records behind a stream interface.
// Each request beat is checked against the table by scanning the slot memory one
// entry per clock over the single read port of the slot RAM; a clear request skips
// the scan. One status beat comes out for every request; a finished status waits in
// the output register while the next request is taken. Slot contents need no
// clearing pass after reset: per-slot valid bits in flip-flops mark which entries
// hold a host.
module source_sequence_duplicate_table #(
    parameter int ENTRIES = sdt_pkg::ENTRIES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sdt_pkg::IN_DATA_W-1:0]    s_tdata,   // host_id[15:0], seq_num[23:16]
    input  logic [sdt_pkg::FUNC_W-1:0]       s_tuser,   // func[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdt_pkg::OUT_DATA_W-1:0]   m_tdata    // status[2:0], zero [7:3]
);
    import sdt_pkg::*;

    ctrl_cmd_t           cmd;
    dp_status_t          dp_status;
    logic [STATUS_W-1:0] status;

    sdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    sdt_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_func    (s_tuser),
        .in_host    (s_tdata[HOST_W-1:0]),
        .in_seq     (s_tdata[HOST_W+SEQ_W-1:HOST_W]),
        .cmd        (cmd),
        .dp_status  (dp_status),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status)
    );

    assign m_tdata = {{(OUT_DATA_W-STATUS_W){1'b0}}, status};

endmodule

### rtl/core/sdt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/sdt_ctrl.sv
// Controller state machine: sequences accept, scan, resolve and result hand-off.
module sdt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sdt_pkg::dp_status_t dp_status,
    output sdt_pkg::ctrl_cmd_t cmd
);
    import sdt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = dp_status.in_is_clear ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (dp_status.idx_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // let the last compare land
                state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (dp_status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/sdt_dp.sv
// Datapath: request registers, valid bits, slot memory, scan compare and output beat.
module sdt_dp #(
    parameter int ENTRIES = sdt_pkg::ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sdt_pkg::FUNC_W-1:0]      in_func,
    input  logic [sdt_pkg::HOST_W-1:0]      in_host,
    input  logic [sdt_pkg::SEQ_W-1:0]       in_seq,
    input  sdt_pkg::ctrl_cmd_t              cmd,
    output sdt_pkg::dp_status_t             dp_status,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sdt_pkg::STATUS_W-1:0]    out_status
);
    import sdt_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MEM_W = HOST_W + SEQ_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    func_t             func_reg;
    logic [HOST_W-1:0] host_reg;
    logic [SEQ_W-1:0]  seq_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_en_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [SEQ_W-1:0]   hit_seq_reg;
    logic               free_reg;
    logic [IDX_W-1:0]   free_idx_reg;

    status_t            status_reg;
    status_t            status_next;
    logic               out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [MEM_W-1:0]   rd_data;
    logic [HOST_W-1:0]  rd_host;
    logic [SEQ_W-1:0]   rd_seq;
    logic               cmp_valid;
    logic               cmp_hit;

    sdt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({host_reg, seq_reg}),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    assign rd_host   = rd_data[MEM_W-1:SEQ_W];
    assign rd_seq    = rd_data[SEQ_W-1:0];
    assign cmp_valid = valid_reg[cmp_idx_reg];
    assign cmp_hit   = cmp_en_reg && cmp_valid && (rd_host == host_reg);

    assign dp_status.in_is_clear = (func_t'(in_func) == FUNC_CLEAR);
    assign dp_status.idx_last    = (idx_reg == IDX_LAST);
    assign dp_status.out_free    = !out_valid_reg || out_ready;

    // Resolve decision and slot write
    always_comb
    begin
        status_next = ST_NOTFOUND;
        wr_en       = 1'b0;
        wr_addr     = hit_idx_reg;
        priority if (func_reg == FUNC_DELETE)
        begin
            status_next = hit_reg ? ST_DELETED : ST_NOTFOUND;
        end
        else if (hit_reg)
        begin
            if (hit_seq_reg != seq_reg)
            begin
                status_next = ST_UPDATED;
                wr_en       = cmd.resolve;
            end
            else
            begin
                status_next = ST_DUPLICATE;
            end
        end
        else if (func_reg == FUNC_REPLACE)
        begin
            status_next = ST_NOTFOUND;
        end
        else if (free_reg)
        begin
            status_next = ST_ADDED;
            wr_en       = cmd.resolve;
            wr_addr     = free_idx_reg;
        end
        else
        begin
            status_next = ST_FULL;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(in_func);
            host_reg <= in_host;
            seq_reg  <= in_seq;
        end
        if (cmp_hit && !hit_reg)
        begin
            hit_idx_reg <= cmp_idx_reg;
            hit_seq_reg <= rd_seq;
        end
        if (cmp_en_reg && !cmp_valid && !free_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (cmd.load)
        begin
            status_reg <= ST_CLEARED;
        end
        else if (cmd.resolve)
        begin
            status_reg <= status_next;
        end
        if (cmd.emit)
        begin
            out_status_reg <= status_reg;
        end
        cmp_idx_reg <= idx_reg;
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            cmp_en_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan;
            if (cmd.load)
            begin
                idx_reg  <= '0;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
                if (func_t'(in_func) == FUNC_CLEAR)
                begin
                    valid_reg <= '0;
                end
            end
            else
            begin
                if (cmd.scan && !dp_status.idx_last)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cmp_hit)
                begin
                    hit_reg <= 1'b1;
                end
                if (cmp_en_reg && !cmp_valid)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.resolve)
            begin
                if (func_reg == FUNC_DELETE && hit_reg)
                begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
                else if (func_reg == FUNC_CHECK && !hit_reg && free_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end
            // hold the beat until taken
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

endmodule

### sim/sdt_status_checker.sv
// Checker for the duplicate table: mirrors the slot table, predicts each status beat, compares.
`timescale 1ns / 1ps

module sdt_status_checker #(
    parameter int ENTRIES = sdt_pkg::ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [sdt_pkg::IN_DATA_W-1:0]  s_tdata,   // host_id[15:0], seq_num[23:16]
    input  logic [sdt_pkg::FUNC_W-1:0]     s_tuser,   // func[1:0]
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [sdt_pkg::OUT_DATA_W-1:0] m_tdata,   // status[2:0], zero [7:3]
    output int                             mismatch_count,
    output int                             outstanding
);
    import sdt_pkg::*;

    bit              slot_valid [ENTRIES];
    bit [HOST_W-1:0] slot_host  [ENTRIES];
    bit [SEQ_W-1:0]  slot_seq   [ENTRIES];

    status_t expected_status [$];

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    // Apply one request to the mirrored table and return the status it yields.
    function automatic status_t predict_status(func_t op, logic [HOST_W-1:0] host,
                                               logic [SEQ_W-1:0] seq);
        int hit;
        int free_slot;
        hit       = -1;
        free_slot = -1;
        if (op == FUNC_CLEAR)
        begin
            for (int i = 0; i < ENTRIES; i++)
                slot_valid[i] = 1'b0;
            return ST_CLEARED;
        end
        // Walk downward so the lowest matching and lowest free index win.
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (slot_valid[i] && slot_host[i] == host)
                hit = i;
            if (!slot_valid[i])
                free_slot = i;
        end
        if (op == FUNC_DELETE)
        begin
            if (hit < 0)
                return ST_NOTFOUND;
            slot_valid[hit] = 1'b0;
            return ST_DELETED;
        end
        if (hit >= 0)
        begin
            if (slot_seq[hit] == seq)
                return ST_DUPLICATE;
            slot_seq[hit] = seq;
            return ST_UPDATED;
        end
        if (op == FUNC_REPLACE)
            return ST_NOTFOUND;
        if (free_slot < 0)
            return ST_FULL;
        slot_valid[free_slot] = 1'b1;
        slot_host[free_slot]  = host;
        slot_seq[free_slot]   = seq;
        return ST_ADDED;
    endfunction

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_status.push_back(predict_status(func_t'(s_tuser),
                                                         s_tdata[HOST_W-1:0],
                                                         s_tdata[HOST_W +: SEQ_W]));
            if (m_tvalid && m_tready)
            begin
                if (expected_status.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: status beat 0x%02h with no request pending",
                                 $realtime, m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (m_tdata !== OUT_DATA_W'(want))
                    begin
                        if (mismatch_count < 10)
                            $display("%0t: status mismatch, expected %0d, got 0x%02h",
                                     $realtime, want, m_tdata);
                        mismatch_count++;
                    end
                end
            end
            outstanding = expected_status.size();
        end
    end

endmodule

### sim/tb_source_sequence_duplicate_table.sv
// Testbench top for the duplicate table: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module tb_source_sequence_duplicate_table;
    import sdt_pkg::*;

    localparam int POOL_SIZE    = 24;
    localparam int RANDOM_ITEMS = 700;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [FUNC_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int mismatch_count;
    int outstanding;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_left = 0;

    always #6 clk = ~clk;

    source_sequence_duplicate_table dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sdt_status_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // Receiver back-pressure: switch between always ready, random, sparse and long stalls.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(16, 96);
        end
        else
        begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ready_left[4];
        endcase
    end

    // Send one request beat; drop valid for a random gap between bursts.
    task automatic issue_request(input func_t op, input logic [HOST_W-1:0] host,
                                 input logic [SEQ_W-1:0] seq);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {seq, host};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
    endtask

    initial
    begin : stimulus
        logic [HOST_W-1:0] host_pool [POOL_SIZE];
        logic [HOST_W-1:0] host;
        logic [SEQ_W-1:0]  seq;
        func_t             op;
        int                pick;
        int                delete_weight;
        int                clear_weight;

        delete_weight = 25;
        clear_weight  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the table with spread-out hosts, then hit every status at least once.
        issue_request(FUNC_CHECK, 16'h0000, 8'h00);
        for (int i = 1; i < 16; i++)
            issue_request(FUNC_CHECK, HOST_W'(i * 16'h1111), SEQ_W'(i * 17));
        issue_request(FUNC_CHECK,   16'h8000, 8'h80);   // table full
        issue_request(FUNC_CHECK,   16'hFFFF, 8'hFF);   // duplicate
        issue_request(FUNC_CHECK,   16'h0000, 8'hFF);   // update
        issue_request(FUNC_REPLACE, 16'h1111, 8'h00);   // replace of a stored host
        issue_request(FUNC_REPLACE, 16'h8000, 8'h80);   // replace of an absent host
        issue_request(FUNC_DELETE,  16'h2222, 8'hA5);
        issue_request(FUNC_DELETE,  16'h2222, 8'h5A);   // already gone
        issue_request(FUNC_CHECK,   16'h8000, 8'h80);   // reuses the freed slot
        issue_request(FUNC_CLEAR,   16'h1234, 8'h56);

        host_pool[0] = 16'h0000;
        host_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            host_pool[i] = HOST_W'($urandom);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // Alternate fill-heavy stretches with churn-heavy ones.
            if (n % 50 == 0)
            begin
                delete_weight = $urandom_range(0, 1) ? 5 : 25;
                clear_weight  = ($urandom_range(0, 2) == 0) ? 4 : 0;
            end
            pick = $urandom_range(0, 99);
            if (pick < clear_weight)
                op = FUNC_CLEAR;
            else if (pick < clear_weight + delete_weight)
                op = FUNC_DELETE;
            else if (pick < clear_weight + delete_weight + 18)
                op = FUNC_REPLACE;
            else
                op = FUNC_CHECK;
            host = ($urandom_range(0, 9) == 0) ? HOST_W'($urandom)
                                               : host_pool[$urandom_range(0, POOL_SIZE - 1)];
            seq  = $urandom_range(0, 1) ? SEQ_W'($urandom_range(0, 2)) : SEQ_W'($urandom);
            issue_request(op, host, seq);
        end
        s_tvalid <= 1'b0;

        // Let the checker take in the last accepted beat before polling its count.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (ENTRIES_DEF + 8) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("source_sequence_duplicate_table regression: pass");
        else
            $display("source_sequence_duplicate_table regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("source_sequence_duplicate_table regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sdt_pkg.sv
rtl/core/sdt_ram.sv
rtl/core/sdt_ctrl.sv
rtl/core/sdt_dp.sv
rtl/core/source_sequence_duplicate_table.sv
sim/sdt_status_checker.sv
sim/tb_source_sequence_duplicate_table.sv
